// ----- src/lceg_pkg.sv -----
// lceg_pkg.sv: types, mode codes and arithmetic constants of the LED color effect generator.
// No dependencies; every module in src imports it.
package lceg_pkg;

	localparam int unsigned CH_W  = 8;
	localparam int unsigned CNT_W = 16;
	localparam int unsigned LANES = 3;
	localparam int unsigned QUO_W = 9;   // hue reaches 359, breath saturates at quotient 256
	localparam int unsigned NUM_W = 25;  // count*360 is the widest dividend

	localparam logic [CNT_W-1:0] PERIOD_RESET = 16'd1000;
	localparam logic [CNT_W-1:0] PERIOD_MIN   = 16'd1;
	localparam logic [8:0]       HUE_FULL     = 9'd360;
	localparam logic [4:0]       FLOOR_DIV    = 5'd20;
	localparam logic [CH_W-1:0]  CH_MAX       = 8'd255;

	// ch*scale/100: values at or above the limit saturate, the rest use a reciprocal
	localparam logic [15:0]      BRT_SAT_LIM  = 16'd25600;
	localparam logic [12:0]      BRT_RECIP    = 13'd5243;
	localparam int unsigned      BRT_SHIFT    = 19;

	// ch/20 for the breath floor
	localparam logic [7:0]       D20_RECIP    = 8'd205;
	localparam int unsigned      D20_SHIFT    = 12;

	typedef enum logic [1:0] {
		MODE_BREATH  = 2'd0,
		MODE_FLASH   = 2'd1,
		MODE_RAINBOW = 2'd2,
		MODE_BRIGHT  = 2'd3
	} mode_t;

	typedef logic [CH_W-1:0] chan_t;

	typedef struct packed {
		mode_t             mode;
		chan_t             red_in;
		chan_t             green_in;
		chan_t             blue_in;
		logic [CNT_W-1:0]  count;
		chan_t             scale;
	} req_t;

	typedef struct packed {
		chan_t red_out;
		chan_t green_out;
		chan_t blue_out;
	} rsp_t;

	// Per-item data that rides alongside the divider; lane 0 red, 1 green, 2 blue
	typedef struct packed {
		mode_t                   mode;
		chan_t [LANES-1:0]       rgb;
		logic                    blk;   // count at or past the period
		logic                    flr;   // breath factor under the 1/20 floor
		chan_t [LANES-1:0]       brt;   // finished brightness result
		logic [LANES-1:0][3:0]   d20;   // channel / 20
	} side_t;

	typedef struct packed {
		side_t                       side;
		logic [LANES-1:0][NUM_W-1:0] num;
	} div_in_t;

	typedef struct packed {
		side_t                       side;
		logic [LANES-1:0][QUO_W-1:0] quo;
	} div_out_t;

endpackage

// ----- src/lceg_front.sv -----
// lceg_front.sv: two pipeline stages that form the dividends and finish the brightness path.
// Depends on lceg_pkg.
module lceg_front import lceg_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [CNT_W-1:0] period,
	input  logic             up_valid,
	output logic             up_ready,
	input  req_t             up,
	output logic             dn_valid,
	input  logic             dn_ready,
	output div_in_t          dn
);

	logic rdy_s1;
	logic rdy_s2;

	// stage 1 next values
	chan_t [LANES-1:0]       ch;
	logic [CNT_W-1:0]        d;
	logic [LANES-1:0][15:0]  sx;
	logic [LANES-1:0][3:0]   d20;

	// stage 1 registers
	logic                    v_s1;
	mode_t                   mode_s1;
	chan_t [LANES-1:0]       rgb_s1;
	logic [CNT_W-1:0]        cnt_s1;
	logic [CNT_W-1:0]        d_s1;
	logic                    blk_s1;
	logic [LANES-1:0][15:0]  sx_s1;
	logic [LANES-1:0][3:0]   d20_s1;

	// stage 2
	div_in_t                 nxt_s2;
	logic                    v_s2;
	div_in_t                 dat_s2;

	assign rdy_s2   = ~v_s2 | dn_ready;
	assign rdy_s1   = ~v_s1 | rdy_s2;
	assign up_ready = rdy_s1;
	assign dn_valid = v_s2;
	assign dn       = dat_s2;

	always_comb begin
		logic [15:0] p20;
		ch[0] = up.red_in;
		ch[1] = up.green_in;
		ch[2] = up.blue_in;
		d = (period > up.count) ? (period - up.count) : (up.count - period);
		for (int l = 0; l < LANES; l++) begin
			sx[l]  = 16'(ch[l]) * 16'(up.scale);
			p20    = 16'(ch[l]) * 16'(D20_RECIP);
			d20[l] = p20[D20_SHIFT+3:D20_SHIFT];
		end
	end

	always_comb begin
		logic [NUM_W-1:0] hn;
		logic [20:0]      dx20;
		logic [27:0]      bp;
		nxt_s2.side.mode = mode_s1;
		nxt_s2.side.rgb  = rgb_s1;
		nxt_s2.side.blk  = blk_s1;
		nxt_s2.side.d20  = d20_s1;
		dx20 = 21'(d_s1) * 21'(FLOOR_DIV);
		nxt_s2.side.flr = dx20 < 21'(period);
		for (int l = 0; l < LANES; l++) begin
			nxt_s2.num[l] = NUM_W'(rgb_s1[l]) * NUM_W'(d_s1);
			bp = 28'(sx_s1[l][14:0]) * 28'(BRT_RECIP);
			nxt_s2.side.brt[l] = (sx_s1[l] >= BRT_SAT_LIM) ? CH_MAX
				: bp[BRT_SHIFT+CH_W-1:BRT_SHIFT];
		end
		// hue wheel borrows the red lane of the divider
		hn = NUM_W'(cnt_s1) * NUM_W'(HUE_FULL);
		if (mode_s1 == MODE_RAINBOW) begin
			nxt_s2.num[0] = hn;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= up_valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && up_valid) begin
			mode_s1 <= up.mode;
			rgb_s1  <= ch;
			cnt_s1  <= up.count;
			d_s1    <= d;
			blk_s1  <= up.count >= period;
			sx_s1   <= sx;
			d20_s1  <= d20;
		end
		if (rdy_s2 && v_s1) begin
			dat_s2 <= nxt_s2;
		end
	end

endmodule

// ----- src/lceg_div.sv -----
// lceg_div.sv: restoring divider over three lanes, one quotient bit per pipeline stage.
// Depends on lceg_pkg.
module lceg_div import lceg_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [CNT_W-1:0] period,
	input  logic             up_valid,
	output logic             up_ready,
	input  div_in_t          up,
	output logic             dn_valid,
	input  logic             dn_ready,
	output div_out_t         dn
);

	localparam int unsigned STEPS = QUO_W;

	typedef struct packed {
		side_t                       side;
		logic [LANES-1:0][NUM_W-1:0] rem;
		logic [LANES-1:0][QUO_W-1:0] quo;
	} step_t;

	logic [STEPS:0]   rdy;
	logic [STEPS-1:0] vld_sk;
	step_t            sin    [STEPS];
	step_t            nxt    [STEPS];
	step_t            dat_sk [STEPS];

	always_comb begin
		rdy[STEPS] = dn_ready;
		for (int k = STEPS - 1; k >= 0; k--) begin
			rdy[k] = ~vld_sk[k] | rdy[k+1];
		end
	end

	always_comb begin
		sin[0].side = up.side;
		sin[0].rem  = up.num;
		sin[0].quo  = '0;
		for (int k = 1; k < STEPS; k++) begin
			sin[k] = dat_sk[k-1];
		end
	end

	// stage k decides quotient bit STEPS-1-k against the shifted divisor
	always_comb begin
		logic [NUM_W-1:0] dsh;
		for (int k = 0; k < STEPS; k++) begin
			nxt[k] = sin[k];
			dsh = NUM_W'(period) << (STEPS - 1 - k);
			for (int l = 0; l < LANES; l++) begin
				if (sin[k].rem[l] >= dsh) begin
					nxt[k].rem[l] = sin[k].rem[l] - dsh;
					nxt[k].quo[l][STEPS-1-k] = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sk <= '0;
		end else begin
			if (rdy[0]) begin
				vld_sk[0] <= up_valid;
			end
			for (int k = 1; k < STEPS; k++) begin
				if (rdy[k]) begin
					vld_sk[k] <= vld_sk[k-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < STEPS; k++) begin
			if (rdy[k]) begin
				dat_sk[k] <= nxt[k];
			end
		end
	end

	assign up_ready = rdy[0];
	assign dn_valid = vld_sk[STEPS-1];
	assign dn.side  = dat_sk[STEPS-1].side;
	assign dn.quo   = dat_sk[STEPS-1].quo;

endmodule

// ----- src/lceg_back.sv -----
// lceg_back.sv: hue sector decode, breath saturation and the final mode select with output register.
// Depends on lceg_pkg.
module lceg_back import lceg_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     up_valid,
	output logic     up_ready,
	input  div_out_t up,
	output logic     dn_valid,
	input  logic     dn_ready,
	output rsp_t     dn
);

	localparam logic [9:0] OFF_MUL = 10'd17;

	typedef enum logic [2:0] {
		SEC_RY = 3'd0,
		SEC_YG = 3'd1,
		SEC_GC = 3'd2,
		SEC_CB = 3'd3,
		SEC_BM = 3'd4,
		SEC_MR = 3'd5
	} sector_t;

	logic              rdy_s12;
	logic              rdy_s13;

	chan_t [LANES-1:0] br;
	sector_t           sec;
	chan_t             off;

	logic              v_s12;
	mode_t             mode_s12;
	chan_t [LANES-1:0] rgb_s12;
	logic              blk_s12;
	chan_t [LANES-1:0] br_s12;
	chan_t [LANES-1:0] brt_s12;
	sector_t           sec_s12;
	chan_t             off_s12;

	rsp_t              res;
	logic              v_s13;
	rsp_t              res_s13;

	assign rdy_s13  = ~v_s13 | dn_ready;
	assign rdy_s12  = ~v_s12 | rdy_s13;
	assign up_ready = rdy_s12;
	assign dn_valid = v_s13;
	assign dn       = res_s13;

	always_comb begin
		logic [8:0] hue;
		logic [8:0] base;
		logic [5:0] rem;
		logic [9:0] rm17;
		for (int l = 0; l < LANES; l++) begin
			priority if (up.side.flr) begin
				br[l] = CH_W'(up.side.d20[l]);
			end else if (up.quo[l][QUO_W-1]) begin
				br[l] = CH_MAX;
			end else begin
				br[l] = up.quo[l][CH_W-1:0];
			end
		end
		hue = up.quo[0];
		priority if (hue < 9'd60) begin
			sec  = SEC_RY;
			base = 9'd0;
		end else if (hue < 9'd120) begin
			sec  = SEC_YG;
			base = 9'd60;
		end else if (hue < 9'd180) begin
			sec  = SEC_GC;
			base = 9'd120;
		end else if (hue < 9'd240) begin
			sec  = SEC_CB;
			base = 9'd180;
		end else if (hue < 9'd300) begin
			sec  = SEC_BM;
			base = 9'd240;
		end else begin
			sec  = SEC_MR;
			base = 9'd300;
		end
		rem  = 6'(hue - base);
		rm17 = 10'(rem) * OFF_MUL;
		off  = rm17[9:2];
	end

	always_comb begin
		res.red_out   = rgb_s12[0];
		res.green_out = rgb_s12[1];
		res.blue_out  = rgb_s12[2];
		unique case (mode_s12)
			MODE_BREATH: begin
				res.red_out   = br_s12[0];
				res.green_out = br_s12[1];
				res.blue_out  = br_s12[2];
			end
			MODE_FLASH: begin
				if (blk_s12) begin
					res = '0;
				end
			end
			MODE_RAINBOW: begin
				// past a full period the hue is off the wheel: keep the base color
				if (!blk_s12) begin
					unique case (sec_s12)
						SEC_RY: begin
							res.red_out   = CH_MAX;
							res.green_out = off_s12;
							res.blue_out  = '0;
						end
						SEC_YG: begin
							res.red_out   = CH_MAX - off_s12;
							res.green_out = CH_MAX;
							res.blue_out  = '0;
						end
						SEC_GC: begin
							res.red_out   = '0;
							res.green_out = CH_MAX;
							res.blue_out  = off_s12;
						end
						SEC_CB: begin
							res.red_out   = '0;
							res.green_out = CH_MAX - off_s12;
							res.blue_out  = CH_MAX;
						end
						SEC_BM: begin
							res.red_out   = off_s12;
							res.green_out = '0;
							res.blue_out  = CH_MAX;
						end
						SEC_MR: begin
							res.red_out   = CH_MAX;
							res.green_out = '0;
							res.blue_out  = CH_MAX - off_s12;
						end
						default: begin
							res = '0;
						end
					endcase
				end
			end
			MODE_BRIGHT: begin
				res.red_out   = brt_s12[0];
				res.green_out = brt_s12[1];
				res.blue_out  = brt_s12[2];
			end
			default: begin
				res = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s12 <= 1'b0;
			v_s13 <= 1'b0;
		end else begin
			if (rdy_s12) begin
				v_s12 <= up_valid;
			end
			if (rdy_s13) begin
				v_s13 <= v_s12;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s12 && up_valid) begin
			mode_s12 <= up.side.mode;
			rgb_s12  <= up.side.rgb;
			blk_s12  <= up.side.blk;
			br_s12   <= br;
			brt_s12  <= up.side.brt;
			sec_s12  <= sec;
			off_s12  <= off;
		end
		if (rdy_s13 && v_s12) begin
			res_s13 <= res;
		end
	end

endmodule

// ----- src/led_color_effect_generator_core.sv -----
// LED color effect generator: breath, flash, hue wheel and brightness on one RGB beat.
// Takes one beat per cycle, sustained while the result side does not stall.
// Pipeline: two front stages, the nine-stage restoring divider with one quotient bit per stage,
// then two back stages; stalls collapse bubbles stage by stage.
// Reset clears every valid bit and loads the period register with 1000.
// Depends on lceg_pkg, lceg_front, lceg_div and lceg_back.
module led_color_effect_generator_core import lceg_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata,
	input  logic             req_valid,
	output logic             req_ready,
	input  req_t             req,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output rsp_t             rsp
);

	logic [CNT_W-1:0] period_q;

	logic     fr_valid;
	logic     fr_ready;
	div_in_t  fr;
	logic     dv_valid;
	logic     dv_ready;
	div_out_t dv;

	// a zero period acts as one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RESET;
		end else if (cfg_we) begin
			period_q <= (cfg_wdata == '0) ? PERIOD_MIN : cfg_wdata;
		end
	end

	lceg_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.period   (period_q),
		.up_valid (req_valid),
		.up_ready (req_ready),
		.up       (req),
		.dn_valid (fr_valid),
		.dn_ready (fr_ready),
		.dn       (fr)
	);

	lceg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.period   (period_q),
		.up_valid (fr_valid),
		.up_ready (fr_ready),
		.up       (fr),
		.dn_valid (dv_valid),
		.dn_ready (dv_ready),
		.dn       (dv)
	);

	lceg_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (dv_valid),
		.up_ready (dv_ready),
		.up       (dv),
		.dn_valid (rsp_valid),
		.dn_ready (rsp_ready),
		.dn       (rsp)
	);

`ifndef SYNTH
	a_period_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		period_q != '0)
		else $error("period register holds zero");

	a_front_hold: assert property (@(posedge clk) disable iff (!arst_n)
		fr_valid && !fr_ready |=> fr_valid && $stable(fr))
		else $error("front beat changed while stalled");

	a_div_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dv_valid && !dv_ready |=> dv_valid && $stable(dv))
		else $error("divider beat changed while stalled");

	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> rsp_valid && !rsp_ready)
		else $error("input stalled without a blocked result");
`endif

endmodule

// ----- tb/sv/lceg_color_checker.sv -----
`timescale 1ns / 100ps
// lceg_color_checker: watches the config port and both beat channels of the LED effect core,
// predicts each output color and compares it field by field. Depends on lceg_pkg.
module lceg_color_checker import lceg_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata,
	input  logic             req_valid,
	input  logic             req_ready,
	input  req_t             req,
	input  logic             rsp_valid,
	input  logic             rsp_ready,
	input  rsp_t             rsp,
	output int               errors,
	output int               colors_owed
);

	localparam int unsigned SECTOR = 60;

	logic [CNT_W-1:0] period_now = PERIOD_RESET;
	rsp_t             colors_due[$];
	rsp_t             want;
	logic             in_beat, out_beat;

	initial errors = 0;
	initial colors_owed = 0;

	function automatic chan_t clip8(logic [31:0] v);
		return (v > 32'(CH_MAX)) ? CH_MAX : v[7:0];
	endfunction

	function automatic chan_t breath_lane(chan_t ch, logic [31:0] d, logic [31:0] p);
		logic [31:0] w;
		w = 32'(ch);
		// under the 1/20 floor the factor is pinned, not d/p
		if (d * 20 < p)
			return clip8(w / 32'(FLOOR_DIV));
		return clip8(w * d / p);
	endfunction

	function automatic rsp_t effect_color(req_t q, logic [CNT_W-1:0] per);
		logic [31:0] p, c, d, hue;
		chan_t       off;
		rsp_t        o;
		p = (per == '0) ? 32'd1 : 32'(per);
		c = 32'(q.count);
		o = '{q.red_in, q.green_in, q.blue_in};
		case (q.mode)
			MODE_BREATH: begin
				d = (p > c) ? p - c : c - p;
				o.red_out   = breath_lane(q.red_in, d, p);
				o.green_out = breath_lane(q.green_in, d, p);
				o.blue_out  = breath_lane(q.blue_in, d, p);
			end
			MODE_FLASH: begin
				if (c >= p)
					o = '0;
			end
			MODE_RAINBOW: begin
				hue = c * 360 / p;
				off = 8'(((hue % SECTOR) * 17) / 4);
				if (hue < SECTOR)
					o = '{CH_MAX, off, 8'd0};
				else if (hue < 2 * SECTOR)
					o = '{CH_MAX - off, CH_MAX, 8'd0};
				else if (hue < 3 * SECTOR)
					o = '{8'd0, CH_MAX, off};
				else if (hue < 4 * SECTOR)
					o = '{8'd0, CH_MAX - off, CH_MAX};
				else if (hue < 5 * SECTOR)
					o = '{off, 8'd0, CH_MAX};
				else if (hue < 32'(HUE_FULL))
					o = '{CH_MAX, 8'd0, CH_MAX - off};
				// hue past the wheel: pass the color through
			end
			default: begin
				o.red_out   = clip8(32'(q.red_in) * 32'(q.scale) / 100);
				o.green_out = clip8(32'(q.green_in) * 32'(q.scale) / 100);
				o.blue_out  = clip8(32'(q.blue_in) * 32'(q.scale) / 100);
			end
		endcase
		return o;
	endfunction

	assign in_beat  = req_valid && req_ready;
	assign out_beat = rsp_valid && rsp_ready;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_now <= PERIOD_RESET;
			colors_due.delete();
			colors_owed <= 0;
		end else begin
			if (cfg_we)
				period_now <= cfg_wdata;
			// push before pop so a same-edge result still finds its entry
			if (in_beat)
				colors_due.push_back(effect_color(req, period_now));
			if (out_beat) begin
				if (colors_due.size() == 0) begin
					$error("result beat %h with no color expected", rsp);
					errors++;
				end else begin
					want = colors_due.pop_front();
					if (rsp.red_out !== want.red_out) begin
						$error("red_out: expected %0d, got %0d", want.red_out, rsp.red_out);
						errors++;
					end
					if (rsp.green_out !== want.green_out) begin
						$error("green_out: expected %0d, got %0d", want.green_out,
							rsp.green_out);
						errors++;
					end
					if (rsp.blue_out !== want.blue_out) begin
						$error("blue_out: expected %0d, got %0d", want.blue_out, rsp.blue_out);
						errors++;
					end
				end
			end
			colors_owed <= colors_owed + int'(in_beat) - int'(out_beat);
		end
	end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// tb: drives the LED effect core with directed and random color beats under several periods
// and backpressure mixes. Depends on lceg_pkg, lceg_color_checker and the core RTL.
module tb;
	import lceg_pkg::*;

	localparam int SEGMENTS    = 8;
	localparam int SEG_BEATS   = 94;
	localparam int STALL_LIMIT = 5000;
	localparam int TAIL_CYCLES = 20;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic [CNT_W-1:0] cfg_wdata = '0;
	logic             req_valid = 1'b0;
	logic             req_ready;
	req_t             req = '0;
	logic             rsp_valid;
	logic             rsp_ready = 1'b0;
	rsp_t             rsp;

	int               errs;
	int               owed;
	int               idle_pct = 0;
	int               stall_pct = 0;
	int               quiet = 0;

	led_color_effect_generator_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	lceg_color_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.rsp         (rsp),
		.errors      (errs),
		.colors_owed (owed)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		rsp_ready <= ($urandom_range(99) >= stall_pct);
	end

	// end the run when no beat moves while work is outstanding
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (!req_valid && owed == 0)) begin
			quiet <= 0;
		end else if (quiet >= STALL_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	task automatic send_color(req_t item);
		while ($urandom_range(99) < idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		do @(posedge clk); while (!req_ready);
	endtask

	// drop valid and hold until every expected color has come back
	task automatic drain();
		req_valid <= 1'b0;
		do @(posedge clk); while (owed != 0);
	endtask

	task automatic write_period(logic [CNT_W-1:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [CNT_W-1:0] pick_count(logic [CNT_W-1:0] per);
		int p, c, w;
		p = (per == '0) ? 1 : int'(per);
		case ($urandom_range(3))
			0: c = $urandom_range(65535);
			1: c = $urandom_range(p - 1);
			2: begin
				w = (p / 10) + 2;
				c = p - w + $urandom_range(2 * w);
			end
			default: c = $urandom_range(2 * p + 2);
		endcase
		if (c < 0)
			c = 0;
		if (c > 65535)
			c = 65535;
		return c[CNT_W-1:0];
	endfunction

	function automatic chan_t pick_chan();
		case ($urandom_range(7))
			0: return 8'd0;
			1: return CH_MAX;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	function automatic req_t pick_color(logic [CNT_W-1:0] per);
		req_t q;
		q.mode     = mode_t'($urandom_range(3));
		q.red_in   = pick_chan();
		q.green_in = pick_chan();
		q.blue_in  = pick_chan();
		q.count    = pick_count(per);
		q.scale    = ($urandom_range(3) == 0) ? 8'(90 + $urandom_range(20)) :
			8'($urandom_range(255));
		return q;
	endfunction

	initial begin
		logic [CNT_W-1:0] per;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed beats at the reset period of 1000
		send_color('{MODE_BREATH, 8'd255, 8'd128, 8'd1, 16'd0, 8'd0});
		send_color('{MODE_BREATH, 8'd255, 8'd255, 8'd255, 16'd1000, 8'd0});
		send_color('{MODE_BREATH, 8'd200, 8'd100, 8'd40, 16'd950, 8'd0});
		send_color('{MODE_BREATH, 8'd200, 8'd100, 8'd40, 16'd951, 8'd0});
		send_color('{MODE_BREATH, 8'd255, 8'd255, 8'd255, 16'd65535, 8'd255});
		send_color('{MODE_BREATH, 8'd255, 8'd17, 8'd0, 16'd2000, 8'd0});
		send_color('{MODE_FLASH, 8'd10, 8'd20, 8'd30, 16'd999, 8'd0});
		send_color('{MODE_FLASH, 8'd10, 8'd20, 8'd30, 16'd1000, 8'd0});
		send_color('{MODE_FLASH, 8'd255, 8'd255, 8'd255, 16'd0, 8'd0});
		send_color('{MODE_RAINBOW, 8'd1, 8'd2, 8'd3, 16'd0, 8'd0});
		send_color('{MODE_RAINBOW, 8'd1, 8'd2, 8'd3, 16'd166, 8'd0});
		send_color('{MODE_RAINBOW, 8'd1, 8'd2, 8'd3, 16'd167, 8'd0});
		send_color('{MODE_RAINBOW, 8'd1, 8'd2, 8'd3, 16'd334, 8'd0});
		send_color('{MODE_RAINBOW, 8'd1, 8'd2, 8'd3, 16'd500, 8'd0});
		send_color('{MODE_RAINBOW, 8'd1, 8'd2, 8'd3, 16'd667, 8'd0});
		send_color('{MODE_RAINBOW, 8'd1, 8'd2, 8'd3, 16'd833, 8'd0});
		send_color('{MODE_RAINBOW, 8'd1, 8'd2, 8'd3, 16'd834, 8'd0});
		send_color('{MODE_RAINBOW, 8'd1, 8'd2, 8'd3, 16'd999, 8'd0});
		send_color('{MODE_RAINBOW, 8'd1, 8'd2, 8'd3, 16'd1000, 8'd0});
		send_color('{MODE_RAINBOW, 8'd255, 8'd0, 8'd255, 16'd65535, 8'd0});
		send_color('{MODE_BRIGHT, 8'd255, 8'd255, 8'd255, 16'd0, 8'd255});
		send_color('{MODE_BRIGHT, 8'd255, 8'd128, 8'd0, 16'd65535, 8'd100});
		send_color('{MODE_BRIGHT, 8'd77, 8'd200, 8'd255, 16'd12, 8'd0});
		send_color('{MODE_BRIGHT, 8'd255, 8'd99, 8'd1, 16'd4321, 8'd101});

		for (int seg = 0; seg < SEGMENTS; seg++) begin
			case (seg)
				0: per = PERIOD_RESET;
				1: per = 16'd1;
				2: per = 16'hFFFF;
				3: per = 16'd0;       // zero period acts as one
				4: per = 16'd360;
				5: per = 16'(2 + $urandom_range(398));
				6: per = 16'($urandom_range(65535));
				default: per = 16'd1000;
			endcase
			if (seg != 0)
				write_period(per);
			case (seg % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 86; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 86; end
				default: begin idle_pct = 13; stall_pct = 13; end
			endcase
			for (int i = 0; i < SEG_BEATS; i++)
				send_color(pick_color(per));
		end

		drain();
		stall_pct = 0;
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errs == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
